/* src/smcp_pkg.sv */
// Types, codes and constants shared by the serial motor command parser.
// No dependencies.
package smcp_pkg;

  localparam int MotorCountDef = 12;
  localparam int MsgMaxDef     = 32;
  localparam int KeptBytes     = 7;
  localparam int KeptAw        = 3;
  localparam int JobDepth      = 2;
  localparam int JobAw         = 1;
  localparam int WideIdMax     = 99;
  localparam int PosMax        = 100;

  localparam logic [7:0] CrByte  = 8'd13;
  localparam logic [7:0] ChOn    = 8'h61;
  localparam logic [7:0] ChOff   = 8'h62;
  localparam logic [7:0] ChCheck = 8'h63;
  localparam logic [7:0] ChOrig  = 8'h66;
  localparam logic [7:0] ChSMin  = 8'h6c;
  localparam logic [7:0] ChSMax  = 8'h68;
  localparam logic [7:0] ChMMax  = 8'h77;
  localparam logic [7:0] ChMMin  = 8'h73;
  localparam logic [7:0] ChCtrl  = 8'h6d;

  // Digit offsets: 48*10+48 for the id, 48*100+48*10+48 for the position.
  localparam logic [12:0] IdBias  = 13'd528;
  localparam logic [15:0] PosBias = 16'd5328;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBadId  = 2'd1,
    StBadPos = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    KOn      = 4'd0,
    KOff     = 4'd1,
    KCheck   = 4'd2,
    KOrigin  = 4'd3,
    KSetMin  = 4'd4,
    KSetMax  = 4'd5,
    KMoveMax = 4'd6,
    KMoveMin = 4'd7,
    KControl = 4'd8
  } kind_e;

  typedef struct packed {
    status_e     status;
    kind_e       kind;
    logic [6:0]  id;
    logic [6:0]  pct;
    logic        bcast;
  } job_t;

  typedef struct packed {
    status_e     status;
    kind_e       kind;
    logic [6:0]  id;
    logic [6:0]  pct;
    logic        last;
  } res_t;

endpackage

/* src/smcp_front.sv */
// Front end: collects message bytes, decodes the command at message end.
// Depends on smcp_pkg.
module smcp_front #(
  parameter int MOTOR_COUNT = smcp_pkg::MotorCountDef,
  parameter int MSG_MAX     = smcp_pkg::MsgMaxDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_i,
  input  logic [7:0]         rx_byte_i,
  output logic               job_push_o,
  output smcp_pkg::job_t     job_o
);

  localparam int LW = $clog2(MSG_MAX);

  logic [7:0]    bytes_q [smcp_pkg::KeptBytes];
  logic [7:0]    bytes_d [smcp_pkg::KeptBytes];
  logic [LW-1:0] len_q, len_d;
  logic          msg_end;

  logic               known, can_bcast, wide;
  smcp_pkg::kind_e    kind;
  logic signed [12:0] id_s;
  logic [15:0]        pos;
  logic [12:0]        limit;
  logic               id_ok;

  assign msg_end = (rx_byte_i == smcp_pkg::CrByte) || (len_q == LW'(MSG_MAX - 1));

  always_comb begin
    known     = 1'b1;
    can_bcast = 1'b0;
    wide      = 1'b1;
    kind      = smcp_pkg::KOn;
    unique case (bytes_q[0])
      smcp_pkg::ChOn: begin
        kind = smcp_pkg::KOn; can_bcast = 1'b1; wide = 1'b0;
      end
      smcp_pkg::ChOff: begin
        kind = smcp_pkg::KOff; can_bcast = 1'b1; wide = 1'b0;
      end
      smcp_pkg::ChCheck: begin
        kind = smcp_pkg::KCheck; wide = 1'b0;
      end
      smcp_pkg::ChOrig: begin
        kind = smcp_pkg::KOrigin; can_bcast = 1'b1; wide = 1'b0;
      end
      smcp_pkg::ChSMin: kind = smcp_pkg::KSetMin;
      smcp_pkg::ChSMax: kind = smcp_pkg::KSetMax;
      smcp_pkg::ChMMax: kind = smcp_pkg::KMoveMax;
      smcp_pkg::ChMMin: kind = smcp_pkg::KMoveMin;
      smcp_pkg::ChCtrl: kind = smcp_pkg::KControl;
      default:          known = 1'b0;
    endcase
  end

  assign id_s  = $signed(13'(bytes_q[1]) * 13'd10 + 13'(bytes_q[2]) - smcp_pkg::IdBias);
  assign pos   = 16'(bytes_q[4]) * 16'd100 + 16'(bytes_q[5]) * 16'd10
               + 16'(bytes_q[6]) - smcp_pkg::PosBias;
  assign limit = wide ? 13'(smcp_pkg::WideIdMax) : 13'(MOTOR_COUNT);
  assign id_ok = (id_s > 13'sd0) && (id_s <= $signed(limit));

  always_comb begin
    job_o.status = smcp_pkg::StOk;
    job_o.kind   = kind;
    job_o.id     = 7'(id_s);
    job_o.pct    = 7'd0;
    job_o.bcast  = 1'b0;
    priority if (can_bcast && (len_q <= LW'(1))) begin
      job_o.bcast = 1'b1;
      job_o.id    = 7'd0;
    end else if (!id_ok) begin
      job_o.status = smcp_pkg::StBadId;
      job_o.id     = 7'd0;
    end else if (kind == smcp_pkg::KControl) begin
      if (pos > 16'(smcp_pkg::PosMax)) begin
        job_o.status = smcp_pkg::StBadPos;
        job_o.id     = 7'd0;
      end else begin
        job_o.pct = 7'(pos);
      end
    end
  end

  assign job_push_o = beat_i && msg_end && known;

  always_comb begin
    bytes_d = bytes_q;
    len_d   = len_q;
    if (beat_i) begin
      if (msg_end) begin
        for (int i = 0; i < smcp_pkg::KeptBytes; i++) bytes_d[i] = 8'd0;
        len_d = '0;
      end else begin
        if (len_q < LW'(smcp_pkg::KeptBytes)) begin
          bytes_d[len_q[smcp_pkg::KeptAw-1:0]] = rx_byte_i;
        end
        len_d = len_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      for (int i = 0; i < smcp_pkg::KeptBytes; i++) bytes_q[i] <= 8'd0;
    end else begin
      len_q   <= len_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

/* src/smcp_job_fifo.sv */
// Short job queue between the decoder front end and the result back end.
// Depends on smcp_pkg.
module smcp_job_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  smcp_pkg::job_t     job_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               nonempty_o,
  output smcp_pkg::job_t     job_o
);

  localparam int AW = smcp_pkg::JobAw;

  smcp_pkg::job_t mem_q [smcp_pkg::JobDepth];
  logic [AW-1:0]  wptr_q, rptr_q;
  logic [AW:0]    cnt_q;
  logic           do_push, do_pop;

  assign full_o     = (cnt_q == (AW+1)'(smcp_pkg::JobDepth));
  assign nonempty_o = (cnt_q != '0);
  assign job_o      = mem_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + AW'(1);
      if (do_pop)  rptr_q <= rptr_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

/* src/smcp_back.sv */
// Back end: expands jobs into results, broadcast ones over all motors.
// Depends on smcp_pkg.
module smcp_back #(
  parameter int MOTOR_COUNT = smcp_pkg::MotorCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  smcp_pkg::job_t     job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_pop_i,
  output smcp_pkg::res_t     res_o
);

  localparam int CW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  logic           valid_q, valid_d;
  smcp_pkg::res_t res_q, res_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           advance, bc_last;

  assign advance = !valid_q || out_pop_i;
  assign bc_last = (cnt_q == CW'(MOTOR_COUNT - 1));

  always_comb begin
    valid_d   = valid_q;
    res_d     = res_q;
    cnt_d     = cnt_q;
    job_pop_o = 1'b0;
    if (advance) begin
      valid_d      = job_valid_i;
      res_d.status = job_i.status;
      res_d.kind   = job_i.kind;
      res_d.pct    = job_i.pct;
      if (job_i.bcast) begin
        res_d.id   = 7'(cnt_q) + 7'd1;
        res_d.last = bc_last;
      end else begin
        res_d.id   = job_i.id;
        res_d.last = 1'b1;
      end
      if (job_valid_i) begin
        if (job_i.bcast && !bc_last) begin
          cnt_d = cnt_q + CW'(1);
        end else begin
          cnt_d     = '0;
          job_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* src/serial_motor_command_parser.sv */
// A message-ending byte's job goes into the job queue, then the result register.
// Throughput: one byte per cycle in while full is low, one result per cycle out
// while pop is held; a broadcast occupies the result stage for MOTOR_COUNT results
// and full rises while the two-entry job queue holds two jobs.
// Reset: asynchronous, clears the message, the job queue and the result stage.
// Top level of the serial motor command parser; depends on smcp_pkg and submodules.
module serial_motor_command_parser_core #(
  parameter int MOTOR_COUNT = smcp_pkg::MotorCountDef,
  parameter int MSG_MAX     = smcp_pkg::MsgMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status_o,
  output logic [3:0] cmd_kind_o,
  output logic [6:0] motor_id_o,
  output logic [6:0] position_pct_o,
  output logic       last_o
);

  logic           beat, front_push, q_full, q_nonempty, q_pop, out_valid;
  smcp_pkg::job_t front_job, q_job;
  smcp_pkg::res_t res;

  assign beat = push && !full;
  assign full = q_full;

  smcp_front #(
    .MOTOR_COUNT(MOTOR_COUNT),
    .MSG_MAX    (MSG_MAX)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .rx_byte_i (rx_byte_i),
    .job_push_o(front_push),
    .job_o     (front_job)
  );

  smcp_job_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (front_push),
    .job_i     (front_job),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .nonempty_o(q_nonempty),
    .job_o     (q_job)
  );

  smcp_back #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_nonempty),
    .job_i      (q_job),
    .job_pop_o  (q_pop),
    .out_valid_o(out_valid),
    .out_pop_i  (pop),
    .res_o      (res)
  );

  assign empty          = !out_valid;
  assign status_o       = res.status;
  assign cmd_kind_o     = res.kind;
  assign motor_id_o     = res.id;
  assign position_pct_o = res.pct;
  assign last_o         = res.last;

endmodule

/* src/smcp_checker.sv */
// Port-level checks for the serial motor command parser, bound to the top level.
// Depends on smcp_pkg and serial_motor_command_parser_core.
module smcp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [1:0] status_o,
  input logic [3:0] cmd_kind_o,
  input logic [6:0] motor_id_o,
  input logic [6:0] position_pct_o,
  input logic       last_o
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("outputs not quiet in reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(cmd_kind_o)
                          && $stable(motor_id_o) && $stable(position_pct_o)
                          && $stable(last_o)))
    else $error("stalled result changed");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o != smcp_pkg::StOk)) |->
      (last_o && (motor_id_o == 7'd0) && (position_pct_o == 7'd0)))
    else $error("malformed error result");

  a_ok_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == smcp_pkg::StOk)) |->
      ((motor_id_o != 7'd0) && (motor_id_o <= 7'd99)))
    else $error("issued command with bad id");

  a_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (cmd_kind_o != smcp_pkg::KControl)) |-> (position_pct_o == 7'd0))
    else $error("position on non-control result");

endmodule

bind serial_motor_command_parser_core smcp_checker u_smcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .status_o      (status_o),
  .cmd_kind_o    (cmd_kind_o),
  .motor_id_o    (motor_id_o),
  .position_pct_o(position_pct_o),
  .last_o        (last_o)
);

/* verif/serial_motor_command_parser_core_test.sv */
// Self-checking bench for serial_motor_command_parser_core: text bytes in, motor commands out.
// Predicts every command beat from its own message parser and checks them in order.
// Depends on smcp_pkg and the parser RTL.
module serial_motor_command_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MotorCount   = smcp_pkg::MotorCountDef;
  localparam int MsgLen       = smcp_pkg::MsgMaxDef;
  localparam int DigitZero    = 48;
  localparam int Tens         = 10;
  localparam int Hundreds     = 100;
  localparam int ItemsGoal    = 210;
  localparam int LongHold     = 150;
  localparam int SettleCycles = 10;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       push      = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic       pop       = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] status_o;
  logic [3:0] cmd_kind_o;
  logic [6:0] motor_id_o;
  logic [6:0] position_pct_o;
  logic       last_o;

  logic [7:0]     line_buf [smcp_pkg::KeptBytes];
  int             line_len     = 0;
  smcp_pkg::res_t owed_cmds [$];
  int             errors       = 0;
  int             sent_beats   = 0;
  int             rx_long_hold = 0;
  bit             steady_flow  = 1'b0;
  logic [7:0]     cmd_letters [9] = '{smcp_pkg::ChOn, smcp_pkg::ChOff, smcp_pkg::ChCheck,
                                      smcp_pkg::ChOrig, smcp_pkg::ChSMin, smcp_pkg::ChSMax,
                                      smcp_pkg::ChMMax, smcp_pkg::ChMMin, smcp_pkg::ChCtrl};

  serial_motor_command_parser_core #(
    .MOTOR_COUNT(MotorCount),
    .MSG_MAX    (MsgLen)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .rx_byte_i     (rx_byte_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .cmd_kind_o    (cmd_kind_o),
    .motor_id_o    (motor_id_o),
    .position_pct_o(position_pct_o),
    .last_o        (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    smcp_pkg::kind_e kind;
    bit              known;
    bit              fans_out;
    bit              wide_ids;
    int              id;
    int              lim;
    int              v;
    logic [15:0]     pos;
    if (b != smcp_pkg::CrByte && line_len < MsgLen - 1) begin
      if (line_len < smcp_pkg::KeptBytes) line_buf[line_len] = b;
      line_len++;
    end else begin
      known    = 1'b1;
      fans_out = 1'b0;
      wide_ids = 1'b1;
      kind     = smcp_pkg::KOn;
      case (line_buf[0])
        smcp_pkg::ChOn: begin
          kind = smcp_pkg::KOn; fans_out = 1'b1; wide_ids = 1'b0;
        end
        smcp_pkg::ChOff: begin
          kind = smcp_pkg::KOff; fans_out = 1'b1; wide_ids = 1'b0;
        end
        smcp_pkg::ChCheck: begin
          kind = smcp_pkg::KCheck; wide_ids = 1'b0;
        end
        smcp_pkg::ChOrig: begin
          kind = smcp_pkg::KOrigin; fans_out = 1'b1; wide_ids = 1'b0;
        end
        smcp_pkg::ChSMin: kind = smcp_pkg::KSetMin;
        smcp_pkg::ChSMax: kind = smcp_pkg::KSetMax;
        smcp_pkg::ChMMax: kind = smcp_pkg::KMoveMax;
        smcp_pkg::ChMMin: kind = smcp_pkg::KMoveMin;
        smcp_pkg::ChCtrl: kind = smcp_pkg::KControl;
        default:          known = 1'b0;
      endcase
      if (known && fans_out && line_len <= 1) begin
        for (int n = 1; n <= MotorCount; n++)
          owed_cmds.push_back('{smcp_pkg::StOk, kind, 7'(n), 7'd0, n == MotorCount});
      end else if (known) begin
        id  = (int'(line_buf[1]) - DigitZero) * Tens + (int'(line_buf[2]) - DigitZero);
        lim = wide_ids ? smcp_pkg::WideIdMax : MotorCount;
        v   = (int'(line_buf[4]) - DigitZero) * Hundreds
            + (int'(line_buf[5]) - DigitZero) * Tens
            + (int'(line_buf[6]) - DigitZero);
        pos = v[15:0];
        if (id <= 0 || id > lim)
          owed_cmds.push_back('{smcp_pkg::StBadId, kind, 7'd0, 7'd0, 1'b1});
        else if (kind == smcp_pkg::KControl && pos > smcp_pkg::PosMax)
          owed_cmds.push_back('{smcp_pkg::StBadPos, kind, 7'd0, 7'd0, 1'b1});
        else
          owed_cmds.push_back('{smcp_pkg::StOk, kind, 7'(id),
                                (kind == smcp_pkg::KControl) ? 7'(pos) : 7'd0, 1'b1});
      end
      foreach (line_buf[i]) line_buf[i] = 8'h00;
      line_len = 0;
    end
  endtask

  task automatic take_result();
    smcp_pkg::res_t want;
    if (owed_cmds.size() == 0) begin
      report_mismatch("unowed beat, cmd_kind", int'(cmd_kind_o), -1);
    end else begin
      want = owed_cmds.pop_front();
      if (status_o !== want.status)
        report_mismatch("status", int'(status_o), int'(want.status));
      if (cmd_kind_o !== want.kind)
        report_mismatch("cmd_kind", int'(cmd_kind_o), int'(want.kind));
      if (motor_id_o !== want.id)
        report_mismatch("motor_id", int'(motor_id_o), int'(want.id));
      if (position_pct_o !== want.pct)
        report_mismatch("position_pct", int'(position_pct_o), int'(want.pct));
      if (last_o !== want.last)
        report_mismatch("last", int'(last_o), int'(want.last));
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [7:0] digit(input int d);
    return 8'(DigitZero + d);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == smcp_pkg::CrByte) ? 8'h00 : b;
  endfunction

  // Hold push high across back-to-back beats; lower it only for a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    parse_byte(b);
    sent_beats++;
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(smcp_pkg::CrByte);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk_i); while (owed_cmds.size() != 0);
  endtask

  task automatic test_each_command();
    send_line("a");
    send_line("b");
    send_line("f");
    send_line("c12");
    send_line("l99");
    send_line("h");
    send_line("w00");
    send_line("s1");
    send_line("m01x100");
  endtask

  task automatic test_special_cases();
    send_line("");
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(smcp_pkg::CrByte);
    send_line("m05x101");
    send_line("m05");
    send_line("c13");
    send_line("m00x050");
    send_byte(smcp_pkg::ChOn);
    send_byte(digit(1));
    send_byte(digit(2));
    for (int n = 3; n < MsgLen - 1; n++) send_byte(n[0] ? 8'hff : 8'h00);
    send_byte(smcp_pkg::ChOn);
    send_byte(smcp_pkg::CrByte);
    send_byte(smcp_pkg::ChMMax);
    send_byte(digit(9));
    send_byte(digit(9));
    for (int n = 3; n < MsgLen - 2; n++) send_byte(8'h20);
    send_byte(smcp_pkg::CrByte);
  endtask

  task automatic test_backpressure();
    steady_flow  = 1'b1;
    rx_long_hold = LongHold;
    repeat (3) begin
      send_line("a");
      send_line("b");
      send_line("f");
    end
    steady_flow = 1'b0;
    drain_results();
  endtask

  task automatic send_random_message();
    logic [7:0] lead;
    int         r;
    int         id;
    int         pct;
    int         n;
    r    = $urandom_range(0, 99);
    lead = cmd_letters[$urandom_range(0, 8)];
    if ($urandom_range(0, 7) == 0) steady_flow = !steady_flow;
    if ($urandom_range(0, 19) == 0) drain_results();
    if ($urandom_range(0, 9) == 0) id = $urandom_range(0, smcp_pkg::WideIdMax);
    else if ($urandom_range(0, 1) == 0) id = $urandom_range(1, MotorCount);
    else id = $urandom_range(1, smcp_pkg::WideIdMax);
    if (r < 12) begin
      if (r < 10) send_byte(lead);
      send_byte(smcp_pkg::CrByte);
    end else if (r < 72) begin
      send_byte(lead);
      send_byte(digit(id / Tens));
      send_byte(digit(id % Tens));
      if (lead == smcp_pkg::ChCtrl) begin
        pct = ($urandom_range(0, 4) == 0) ? $urandom_range(smcp_pkg::PosMax + 1, 999)
                                          : $urandom_range(0, smcp_pkg::PosMax);
        send_byte(text_byte());
        send_byte(digit(pct / Hundreds));
        send_byte(digit(pct / Tens % Tens));
        send_byte(digit(pct % Tens));
      end
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      repeat (n) send_byte(text_byte());
      send_byte(smcp_pkg::CrByte);
    end else if (r < 80) begin
      send_byte(lead);
      repeat ($urandom_range(0, 7)) send_byte(text_byte());
      send_byte(smcp_pkg::CrByte);
    end else if (r < 92) begin
      repeat ($urandom_range(1, 10))
        send_byte(($urandom_range(0, 3) == 0) ? smcp_pkg::CrByte
                                              : 8'($urandom_range(0, 255)));
    end else begin
      send_byte(lead);
      send_byte(digit(id / Tens));
      send_byte(digit(id % Tens));
      for (n = 3; n < MsgLen - 1; n++) send_byte(text_byte());
      send_byte(($urandom_range(0, 1) == 0) ? smcp_pkg::CrByte : text_byte());
    end
  endtask

  task automatic test_random_traffic();
    while (sent_beats < ItemsGoal) send_random_message();
  endtask

  initial begin : result_sink
    int hold_left;
    int r;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) take_result();
      if (rx_long_hold > 0) begin
        hold_left    = rx_long_hold;
        rx_long_hold = 0;
      end
      r = $urandom_range(0, 99);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (steady_flow || r < 70) begin
        pop <= 1'b1;
      end else begin
        pop       <= 1'b0;
        hold_left  = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    foreach (line_buf[i]) line_buf[i] = 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_each_command();
    test_special_cases();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* serial_motor_command_parser_core.f */
src/smcp_pkg.sv
src/smcp_front.sv
src/smcp_job_fifo.sv
src/smcp_back.sv
src/serial_motor_command_parser.sv
src/smcp_checker.sv
verif/serial_motor_command_parser_core_test.sv
